// ===== hdl/spr_pkg.sv =====
// shared types and constants for the stream pattern replace block
// no dependencies; used by every module under hdl
package spr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int WORD_W      = MAX_PATTERN * BYTE_W;
    localparam int FILL_W      = $clog2(MAX_PATTERN);
    localparam int NUM_W       = $clog2(MAX_PATTERN + 1);
    localparam int QUEUE_DEPTH = 2 * MAX_PATTERN;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_ADDR_W  = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LENGTH  = 2'd0,
        CFG_PATTERN = 2'd1,
        CFG_REPLACE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              done;
    } item_t;

    typedef struct packed {
        logic [NUM_W-1:0]             count;
        item_t [MAX_PATTERN-1:0]      item;
    } burst_t;

endpackage

// ===== hdl/spr_cell.sv =====
// one window cell: holds a byte, passes it on, compares the incoming byte
// against its pattern byte; uses spr_pkg
module spr_cell (
    input  logic                      aclk,
    input  logic                      shift_en,
    input  logic [spr_pkg::BYTE_W-1:0] byte_in,
    input  logic [spr_pkg::BYTE_W-1:0] pat_byte,
    output logic [spr_pkg::BYTE_W-1:0] byte_q,
    output logic                      match
);

    logic [spr_pkg::BYTE_W-1:0] byte_reg;
    logic [spr_pkg::BYTE_W-1:0] byte_next;

    always_comb begin
        byte_next = shift_en ? byte_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;
    assign match  = (byte_in == pat_byte);

endmodule

// ===== hdl/spr_matcher.sv =====
// window of chained cells, newest byte in cell 0, plus fill count and
// the logic that builds the items released by each input; uses spr_pkg, spr_cell
module spr_matcher (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [spr_pkg::BYTE_W-1:0] text_byte,
    input  logic                       end_of_line,
    input  logic [spr_pkg::NUM_W-1:0]  eff_len,
    input  logic [spr_pkg::WORD_W-1:0] pattern,
    input  logic [spr_pkg::WORD_W-1:0] replacement,
    output spr_pkg::burst_t            burst
);

    logic [spr_pkg::FILL_W-1:0] fill_reg;
    logic [spr_pkg::FILL_W-1:0] fill_next;

    logic [spr_pkg::BYTE_W-1:0] cell_in  [spr_pkg::MAX_PATTERN];
    logic [spr_pkg::BYTE_W-1:0] cell_q   [spr_pkg::MAX_PATTERN];
    logic [spr_pkg::BYTE_W-1:0] pat_sel  [spr_pkg::MAX_PATTERN];
    logic [spr_pkg::MAX_PATTERN-1:0] cell_match;

    logic [spr_pkg::NUM_W-1:0] new_fill;
    logic [spr_pkg::NUM_W-1:0] excess;
    logic                      full;
    logic                      hit;

    genvar g;
    generate
        for (g = 0; g < spr_pkg::MAX_PATTERN; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_in[g] = text_byte;
            end else begin : g_tail
                assign cell_in[g] = cell_q[g-1];
            end
            spr_cell u_cell (
                .aclk     (aclk),
                .shift_en (step),
                .byte_in  (cell_in[g]),
                .pat_byte (pat_sel[g]),
                .byte_q   (cell_q[g]),
                .match    (cell_match[g])
            );
        end
    endgenerate

    // cell i sees the i-th newest byte at its input, so it meets pattern byte len-1-i
    always_comb begin
        logic [spr_pkg::FILL_W-1:0] pidx;
        pidx = '0;
        for (int i = 0; i < spr_pkg::MAX_PATTERN; i++) begin
            pidx = spr_pkg::FILL_W'(eff_len - spr_pkg::NUM_W'(1) - spr_pkg::NUM_W'(i));
            pat_sel[i] = pattern[pidx*spr_pkg::BYTE_W +: spr_pkg::BYTE_W];
        end
    end

    always_comb begin
        logic [spr_pkg::FILL_W-1:0] widx;
        logic [spr_pkg::FILL_W-1:0] ridx;
        widx     = '0;
        ridx     = '0;
        new_fill = spr_pkg::NUM_W'(fill_reg) + spr_pkg::NUM_W'(1);
        full     = (new_fill >= eff_len);
        excess   = full ? (new_fill - eff_len) : '0;
        hit      = full;
        for (int i = 0; i < spr_pkg::MAX_PATTERN; i++) begin
            if ((spr_pkg::NUM_W'(i) < eff_len) && !cell_match[i]) begin
                hit = 1'b0;
            end
        end

        if (hit) begin
            burst.count = new_fill;
        end else if (end_of_line) begin
            burst.count = new_fill;
        end else if (full) begin
            burst.count = excess + spr_pkg::NUM_W'(1);
        end else begin
            burst.count = '0;
        end

        // items leave oldest first
        for (int j = 0; j < spr_pkg::MAX_PATTERN; j++) begin
            widx = spr_pkg::FILL_W'(new_fill - spr_pkg::NUM_W'(1) - spr_pkg::NUM_W'(j));
            ridx = spr_pkg::FILL_W'(spr_pkg::NUM_W'(j) - excess);
            if (hit && (spr_pkg::NUM_W'(j) >= excess)) begin
                burst.item[j].data = replacement[ridx*spr_pkg::BYTE_W +: spr_pkg::BYTE_W];
            end else begin
                burst.item[j].data = cell_in[widx];
            end
            burst.item[j].done = end_of_line &&
                                 ((spr_pkg::NUM_W'(j) + spr_pkg::NUM_W'(1)) == burst.count);
        end
    end

    always_comb begin
        if (!step) begin
            fill_next = fill_reg;
        end else if (hit || end_of_line) begin
            fill_next = '0;
        end else if (full) begin
            fill_next = spr_pkg::FILL_W'(eff_len - spr_pkg::NUM_W'(1));
        end else begin
            fill_next = spr_pkg::FILL_W'(new_fill);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== hdl/spr_queue.sv =====
// output queue as a chain of cells: head in cell 0, bursts of items appended
// at the tail, one item leaves per cycle while m_ready is high; uses spr_pkg
module spr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  spr_pkg::burst_t burst,
    input  logic            m_ready,
    output logic            m_valid,
    output spr_pkg::item_t  head,
    output logic            space_ok
);

    spr_pkg::item_t entry_reg  [spr_pkg::QUEUE_DEPTH];
    spr_pkg::item_t entry_next [spr_pkg::QUEUE_DEPTH];
    spr_pkg::item_t shift_in   [spr_pkg::QUEUE_DEPTH];

    logic [spr_pkg::QCNT_W-1:0] count_reg;
    logic [spr_pkg::QCNT_W-1:0] count_next;
    logic [spr_pkg::QCNT_W-1:0] base;
    logic [spr_pkg::QCNT_W-1:0] tail;
    logic                       pop;

    genvar g;
    generate
        for (g = 0; g < spr_pkg::QUEUE_DEPTH; g++) begin : g_shift
            if (g < spr_pkg::QUEUE_DEPTH - 1) begin : g_mid
                assign shift_in[g] = entry_reg[g+1];
            end else begin : g_end
                assign shift_in[g] = entry_reg[g];
            end
        end
    endgenerate

    assign pop  = (count_reg != '0) && m_ready;
    assign base = count_reg - spr_pkg::QCNT_W'(pop);
    assign tail = base + spr_pkg::QCNT_W'(burst.count);

    always_comb begin
        logic [spr_pkg::QCNT_W-1:0] off;
        off = '0;
        for (int i = 0; i < spr_pkg::QUEUE_DEPTH; i++) begin
            off = spr_pkg::QCNT_W'(i) - base;
            if (push && (spr_pkg::QCNT_W'(i) >= base) && (spr_pkg::QCNT_W'(i) < tail)) begin
                entry_next[i] = burst.item[off[spr_pkg::FILL_W-1:0]];
            end else if (pop) begin
                entry_next[i] = shift_in[i];
            end else begin
                entry_next[i] = entry_reg[i];
            end
        end
    end

    always_comb begin
        count_next = push ? tail : base;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < spr_pkg::QUEUE_DEPTH; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign m_valid  = (count_reg != '0);
    assign head     = entry_reg[0];
    assign space_ok = (count_reg <=
                       spr_pkg::QCNT_W'(spr_pkg::QUEUE_DEPTH - spr_pkg::MAX_PATTERN));

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= spr_pkg::QCNT_W'(spr_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (int'(base) + int'(burst.count) <= spr_pkg::QUEUE_DEPTH))
        else $error("burst does not fit in queue");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - spr_pkg::QCNT_W'(1)))
        else $error("queue count wrong after pop");

endmodule

// ===== hdl/stream_pattern_replace.sv =====
// stream pattern replace: fixed-length find and replace on a byte stream
// top level; uses spr_pkg, spr_matcher, spr_queue
//
// input channel s_: one text byte per item with s_end_of_line on the last
// byte of a line. output channel m_: one edited byte per item, m_line_done
// on the last byte released for a line. both channels use valid/ready.
// configuration: cfg_we writes cfg_wdata to register cfg_addr (0 length,
// 1 pattern, 2 replacement); write only while the block is idle.
// an item is taken every cycle while the output queue holds at most eight
// items; each item releases up to eight output items into the queue in the
// same cycle, which then leave one per cycle while m_ready is high. the queue's
// single read port sets the output rate at one item per cycle.
// an item released into an empty queue is on m_ in the cycle after the
// input item that releases it; bytes that might start a match are held for up
// to pattern length minus one input items, or until end of line.
// reset: window and queue empty, length 1, pattern and replacement zero.
// receiver stall: the queue fills and s_ready drops once more than eight
// items wait; nothing is lost.
module stream_pattern_replace (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [spr_pkg::BYTE_W-1:0]     s_text_byte,
    input  logic                           s_end_of_line,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [spr_pkg::BYTE_W-1:0]     m_out_byte,
    output logic                           m_line_done,
    input  logic                           cfg_we,
    input  logic [spr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [spr_pkg::WORD_W-1:0]     cfg_wdata
);

    logic [spr_pkg::LEN_W-1:0]  len_reg;
    logic [spr_pkg::WORD_W-1:0] pat_reg;
    logic [spr_pkg::WORD_W-1:0] rep_reg;
    logic [spr_pkg::NUM_W-1:0]  eff_len;
    logic                       step;
    logic                       space_ok;
    spr_pkg::burst_t            burst;
    spr_pkg::item_t             head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= spr_pkg::LEN_W'(1);
            pat_reg <= '0;
            rep_reg <= '0;
        end else if (cfg_we) begin
            case (spr_pkg::cfg_reg_t'(cfg_addr))
                spr_pkg::CFG_LENGTH:  len_reg <= cfg_wdata[spr_pkg::LEN_W-1:0];
                spr_pkg::CFG_PATTERN: pat_reg <= cfg_wdata;
                spr_pkg::CFG_REPLACE: rep_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the window length
    always_comb begin
        if (len_reg == '0) begin
            eff_len = spr_pkg::NUM_W'(1);
        end else if (len_reg > spr_pkg::LEN_W'(spr_pkg::MAX_PATTERN)) begin
            eff_len = spr_pkg::NUM_W'(spr_pkg::MAX_PATTERN);
        end else begin
            eff_len = spr_pkg::NUM_W'(len_reg);
        end
    end

    assign s_ready = space_ok;
    assign step    = s_valid && space_ok;

    spr_matcher u_matcher (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .text_byte   (s_text_byte),
        .end_of_line (s_end_of_line),
        .eff_len     (eff_len),
        .pattern     (pat_reg),
        .replacement (rep_reg),
        .burst       (burst)
    );

    spr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (step),
        .burst    (burst),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .head     (head),
        .space_ok (space_ok)
    );

    assign m_out_byte  = head.data;
    assign m_line_done = head.done;

endmodule
